>>> hw/rtl/crc_checked_sensor_frame_decoder_defines.svh
// assertion macros for the frame decoder rtl
`ifndef CRC_CHECKED_SENSOR_FRAME_DECODER_DEFINES_SVH
`define CRC_CHECKED_SENSOR_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cfd_pkg.sv
// types, codes and the crc-8 step for the sensor frame decoder
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned TEMP_W   = 15;
    localparam int unsigned HUM_W    = 14;
    localparam int unsigned SERIAL_W = 32;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    // scale factors and offsets, all in hundredths
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd12500;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;
    localparam logic [HUM_W-1:0]  HUM_OFFSET  = 14'd600;
    localparam logic [HUM_W-1:0]  HUM_MAX     = 14'd10000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_CRC_A = 2'd1,
        ST_CRC_B = 2'd2
    } t_status;

    typedef enum logic {
        KIND_MEAS   = 1'b0,
        KIND_SERIAL = 1'b1
    } t_frame_kind;

    // byte position within the six-byte frame
    typedef enum logic [5:0] {
        POS_A_HI  = 6'b000001,
        POS_A_LO  = 6'b000010,
        POS_A_CRC = 6'b000100,
        POS_B_HI  = 6'b001000,
        POS_B_LO  = 6'b010000,
        POS_B_CRC = 6'b100000
    } t_pos;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature_centi;
        logic [HUM_W-1:0]  humidity_centi;
    } t_meas;

    // one byte through crc-8, msb first, no reflection
    function automatic logic [BYTE_W-1:0] crc8_step(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cfd_if.sv
// valid/ready channels of the sensor frame decoder
`timescale 1ns / 1ps
`default_nettype none

interface cfd_byte_if;
    logic                  valid;
    logic                  ready;
    logic [cfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_res_if;
    logic                         valid;
    logic                         ready;
    logic [cfd_pkg::STATUS_W-1:0] status;
    logic signed [cfd_pkg::TEMP_W-1:0] temperature_centi;
    logic [cfd_pkg::HUM_W-1:0]    humidity_centi;
    logic [cfd_pkg::SERIAL_W-1:0] serial_number;

    modport source (output valid, output status, output temperature_centi,
                    output humidity_centi, output serial_number, input ready);
    modport sink   (input valid, input status, input temperature_centi,
                    input humidity_centi, input serial_number, output ready);
endinterface

interface cfd_cfg_if;
    logic valid;
    logic ready;
    logic frame_kind;

    modport source (output valid, output frame_kind, input ready);
    modport sink   (input valid, input frame_kind, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cfd_conv.sv
// raw words to centi-degrees and centi-percent
`timescale 1ns / 1ps
`default_nettype none

module cfd_conv (
    input  wire logic [cfd_pkg::WORD_W-1:0] i_temp_raw,
    input  wire logic [cfd_pkg::WORD_W-1:0] i_hum_raw,
    output cfd_pkg::t_meas                  o_meas
);
    import cfd_pkg::*;

    logic [30:0]       temp_prod;
    logic [29:0]       hum_prod;
    logic [31:0]       temp_fold;
    logic [31:0]       hum_fold;
    logic [TEMP_W-1:0] temp_q;
    logic [HUM_W-1:0]  hum_q;

    // x / 65535 == (x + (x >> 16) + 1) >> 16 for these ranges
    always_comb begin
        temp_prod = 31'(TEMP_SCALE * i_temp_raw);
        hum_prod  = 30'(HUM_SCALE * i_hum_raw);
        temp_fold = 32'(temp_prod) + 32'(temp_prod[30:16]) + 32'd1;
        hum_fold  = 32'(hum_prod) + 32'(hum_prod[29:16]) + 32'd1;
        temp_q    = temp_fold[16 +: TEMP_W];
        hum_q     = hum_fold[16 +: HUM_W];

        o_meas.temperature_centi = temp_q - TEMP_OFFSET;
        if (hum_q < HUM_OFFSET) begin
            o_meas.humidity_centi = '0;
        end else if (hum_q - HUM_OFFSET > HUM_MAX) begin
            o_meas.humidity_centi = HUM_MAX;
        end else begin
            o_meas.humidity_centi = hum_q - HUM_OFFSET;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/crc_checked_sensor_frame_decoder.sv
// top level: six-byte sensor response frame decoder with crc-8 checks
`timescale 1ns / 1ps
`default_nettype none

// Takes one response byte per request on i_rx, in frame order: word A high,
// word A low, crc of A, word B high, word B low, crc of B. Each crc is crc-8,
// polynomial 0x31, start 0xff, over the two bytes of its word. The sixth byte
// gives one request on o_res: status (ok, A crc bad, B crc bad; A wins when
// both fail) and, when ok, either temperature and humidity in hundredths
// (frame_kind 0) or the 32-bit serial number A:B (frame_kind 1); fields not
// in use are zero. A byte can be taken every cycle while o_res is not
// stalled, sustained one byte per cycle. A byte is registered in the input
// register, then the frame logic (crc step, word capture, constant multiply
// and 16-bit fold for the divide by 65535) fills the result register, so a
// result is valid once its sixth byte has passed the input register and the frame logic. The
// result register waits for o_res.ready; meanwhile one more byte is held in
// the input register. A frame_kind write is held off while a byte sits in
// the input register, so it applies to every byte taken from then on; it is
// read when the sixth byte is processed, and may change within a frame.
// There is no framing input: reset realigns to the start of a frame.

`include "crc_checked_sensor_frame_decoder_defines.svh"

module crc_checked_sensor_frame_decoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cfd_byte_if.sink  i_rx,
    cfd_cfg_if.sink   i_cfg,
    cfd_res_if.source o_res
);
    import cfd_pkg::*;

    // input register
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;

    // frame state
    t_pos               r_pos, n_pos;
    logic [BYTE_W-1:0]  r_crc, n_crc;
    logic               r_a_ok, n_a_ok;
    logic [WORD_W-1:0]  r_word_a, n_word_a;
    logic [WORD_W-1:0]  r_word_b, n_word_b;
    t_frame_kind        r_frame_kind;

    // result register
    logic               r_res_valid;
    t_status            r_status, n_status;
    logic [TEMP_W-1:0]  r_temp, n_temp;
    logic [HUM_W-1:0]   r_hum, n_hum;
    logic [SERIAL_W-1:0] r_serial, n_serial;

    logic               advance;
    logic               in_accept;
    logic               step;
    logic               frame_done;
    logic [BYTE_W-1:0]  crc_next;
    t_meas              meas;

    // pipeline moves when the result register is free or being emptied
    assign advance     = !r_res_valid || o_res.ready;
    assign i_rx.ready  = !r_in_valid || advance;
    assign in_accept   = i_rx.valid && i_rx.ready;
    assign step        = r_in_valid && advance;
    assign frame_done  = step && (r_pos == POS_B_CRC);
    // no mode change while a taken byte is still unprocessed
    assign i_cfg.ready = !r_in_valid;

    // crc start value on the first byte of each word
    assign crc_next = crc8_step(
        ((r_pos == POS_A_HI) || (r_pos == POS_B_HI)) ? CRC_INIT : r_crc, r_in_byte);

    cfd_conv u_conv (
        .i_temp_raw (r_word_a),
        .i_hum_raw  (r_word_b),
        .o_meas     (meas)
    );

    // frame sequencing, crc and word capture
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_a_ok   = r_a_ok;
        n_word_a = r_word_a;
        n_word_b = r_word_b;
        if (step) begin
            unique case (r_pos)
                POS_A_HI: begin
                    n_crc    = crc_next;
                    n_word_a = {r_in_byte, r_word_a[BYTE_W-1:0]};
                    n_pos    = POS_A_LO;
                end
                POS_A_LO: begin
                    n_crc    = crc_next;
                    n_word_a = {r_word_a[WORD_W-1:BYTE_W], r_in_byte};
                    n_pos    = POS_A_CRC;
                end
                POS_A_CRC: begin
                    n_a_ok = (r_crc == r_in_byte);
                    n_crc  = CRC_INIT;
                    n_pos  = POS_B_HI;
                end
                POS_B_HI: begin
                    n_crc    = crc_next;
                    n_word_b = {r_in_byte, r_word_b[BYTE_W-1:0]};
                    n_pos    = POS_B_LO;
                end
                POS_B_LO: begin
                    n_crc    = crc_next;
                    n_word_b = {r_word_b[WORD_W-1:BYTE_W], r_in_byte};
                    n_pos    = POS_B_CRC;
                end
                POS_B_CRC: begin
                    n_a_ok = 1'b0;
                    n_crc  = CRC_INIT;
                    n_pos  = POS_A_HI;
                end
                default: begin
                    n_pos = POS_A_HI;
                end
            endcase
        end
    end

    // result of the sixth byte
    always_comb begin
        n_temp   = '0;
        n_hum    = '0;
        n_serial = '0;
        priority if (!r_a_ok) begin
            n_status = ST_CRC_A;
        end else if (r_crc != r_in_byte) begin
            n_status = ST_CRC_B;
        end else begin
            n_status = ST_OK;
        end
        if (n_status == ST_OK) begin
            if (r_frame_kind == KIND_MEAS) begin
                n_temp = meas.temperature_centi;
                n_hum  = meas.humidity_centi;
            end else begin
                n_serial = {r_word_a, r_word_b};
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_res_valid  <= 1'b0;
            r_pos        <= POS_A_HI;
            r_crc        <= CRC_INIT;
            r_a_ok       <= 1'b0;
            r_frame_kind <= KIND_MEAS;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (frame_done) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_a_ok <= n_a_ok;
            if (i_cfg.valid && i_cfg.ready) begin
                r_frame_kind <= t_frame_kind'(i_cfg.frame_kind);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx.rx_byte;
        end
        r_word_a <= n_word_a;
        r_word_b <= n_word_b;
        if (frame_done) begin
            r_status <= n_status;
            r_temp   <= n_temp;
            r_hum    <= n_hum;
            r_serial <= n_serial;
        end
    end

    assign o_res.valid             = r_res_valid;
    assign o_res.status            = r_status;
    assign o_res.temperature_centi = r_temp;
    assign o_res.humidity_centi    = r_hum;
    assign o_res.serial_number     = r_serial;

    `CFD_ASSERT_NEXT(a_done_gives_result, i_clk, i_rst_n, frame_done, r_res_valid,
        "frame end without result")
    `CFD_ASSERT_NEXT(a_done_restarts_crc, i_clk, i_rst_n, frame_done,
        (r_crc == CRC_INIT) && (r_pos == POS_A_HI) && !r_a_ok, "frame state not cleared")
    `CFD_ASSERT_NOW(a_bad_crc_zero_fields, i_clk, i_rst_n, r_res_valid && (r_status != ST_OK),
        (r_temp == '0) && (r_hum == '0) && (r_serial == '0), "fields set on crc error")
    `CFD_ASSERT_NOW(a_no_step_on_stall, i_clk, i_rst_n, r_res_valid && !o_res.ready, !step,
        "frame advanced into full result")

endmodule

`default_nettype wire
